/* hdl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants for the matrix to quaternion converter
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int DATA_W        = 16;
	localparam int FRAC_BITS_DEF = 14;

	// which quaternion component takes the half root
	typedef enum logic [1:0] {
		ROOT_X,
		ROOT_Y,
		ROOT_Z,
		ROOT_W
	} rmq_sel_t;

	typedef struct packed {
		logic     valid;
		rmq_sel_t sel;
		logic [2:0] neg;
	} rmq_ctrl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] m00;
		logic signed [DATA_W-1:0] m01;
		logic signed [DATA_W-1:0] m02;
		logic signed [DATA_W-1:0] m10;
		logic signed [DATA_W-1:0] m11;
		logic signed [DATA_W-1:0] m12;
		logic signed [DATA_W-1:0] m20;
		logic signed [DATA_W-1:0] m21;
		logic signed [DATA_W-1:0] m22;
	} rmq_matrix_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quat_x;
		logic signed [DATA_W-1:0] quat_y;
		logic signed [DATA_W-1:0] quat_z;
		logic signed [DATA_W-1:0] quat_w;
		logic                     zero_root;
	} rmq_quat_t;

endpackage

/* hdl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// branch select, root argument and numerator magnitudes, one register stage
// ----------------------------------------------------------------------------
module rmq_front #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
	parameter int AW        = 19,
	parameter int SQ_W      = 34
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  rmq_pkg::rmq_matrix_t                 matrix,
	output rmq_pkg::rmq_ctrl_t                   nxt_ctrl,
	output logic [SQ_W-1:0]                      nxt_rad,
	output logic [2:0][rmq_pkg::DATA_W:0]        nxt_mag
);
	import rmq_pkg::*;

	localparam int W = DATA_W;
	localparam logic signed [AW:0] ONE = (AW+1)'(64'd1 << FRAC_BITS);

	logic signed [W+1:0] e00, e11, e22, tr, dsum;
	logic                tr_pos;
	logic [1:0]          ax;
	logic signed [AW:0]  arg;
	logic [AW-1:0]       arg_u;
	logic signed [W:0]   d [3];
	rmq_sel_t            sel;
	logic [2:0]          neg;
	logic [2:0][W:0]     mag;

	rmq_ctrl_t           ctrl_s1;
	logic [SQ_W-1:0]     rad_s1;
	logic [2:0][W:0]     mag_s1;

	assign e00 = {{2{matrix.m00[W-1]}}, matrix.m00};
	assign e11 = {{2{matrix.m11[W-1]}}, matrix.m11};
	assign e22 = {{2{matrix.m22[W-1]}}, matrix.m22};
	assign tr  = e00 + e11 + e22;
	assign tr_pos = tr > 0;

	// largest diagonal, lower index wins ties
	always_comb begin
		ax = 2'd0;
		if (matrix.m11 > matrix.m00) ax = 2'd1;
		priority if (ax == 2'd1) begin
			if (matrix.m22 > matrix.m11) ax = 2'd2;
		end else begin
			if (matrix.m22 > matrix.m00) ax = 2'd2;
		end
	end

	always_comb begin
		dsum = tr;
		sel  = ROOT_W;
		d[0] = {matrix.m12[W-1], matrix.m12} - {matrix.m21[W-1], matrix.m21};
		d[1] = {matrix.m20[W-1], matrix.m20} - {matrix.m02[W-1], matrix.m02};
		d[2] = {matrix.m01[W-1], matrix.m01} - {matrix.m10[W-1], matrix.m10};
		if (!tr_pos) begin
			unique case (ax)
				2'd0: begin
					sel  = ROOT_X;
					dsum = e00 - e11 - e22;
					d[0] = {matrix.m12[W-1], matrix.m12} - {matrix.m21[W-1], matrix.m21};
					d[1] = {matrix.m01[W-1], matrix.m01} + {matrix.m10[W-1], matrix.m10};
					d[2] = {matrix.m02[W-1], matrix.m02} + {matrix.m20[W-1], matrix.m20};
				end
				2'd1: begin
					sel  = ROOT_Y;
					dsum = e11 - e22 - e00;
					d[0] = {matrix.m20[W-1], matrix.m20} - {matrix.m02[W-1], matrix.m02};
					d[1] = {matrix.m12[W-1], matrix.m12} + {matrix.m21[W-1], matrix.m21};
					d[2] = {matrix.m10[W-1], matrix.m10} + {matrix.m01[W-1], matrix.m01};
				end
				default: begin
					sel  = ROOT_Z;
					dsum = e22 - e00 - e11;
					d[0] = {matrix.m01[W-1], matrix.m01} - {matrix.m10[W-1], matrix.m10};
					d[1] = {matrix.m20[W-1], matrix.m20} + {matrix.m02[W-1], matrix.m02};
					d[2] = {matrix.m21[W-1], matrix.m21} + {matrix.m12[W-1], matrix.m12};
				end
			endcase
		end
	end

	assign arg   = ONE + {{(AW-W-1){dsum[W+1]}}, dsum};
	assign arg_u = (arg > 0) ? arg[AW-1:0] : '0;

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			neg[n] = d[n][W];
			mag[n] = d[n][W] ? (W+1)'(-d[n]) : d[n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= '{valid: start, sel: sel, neg: neg};
		end
	end

	always_ff @(posedge clk) begin
		rad_s1 <= SQ_W'({arg_u, {FRAC_BITS{1'b0}}});
		mag_s1 <= mag;
	end

	assign nxt_ctrl = ctrl_s1;
	assign nxt_rad  = rad_s1;
	assign nxt_mag  = mag_s1;

endmodule

/* hdl/rmq_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// one digit of the integer square root, two radicand bits per cell
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
	parameter int SQ_W = 34,
	parameter int NB   = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmq_pkg::rmq_ctrl_t            cur_ctrl,
	input  logic [SQ_W-1:0]               cur_rad,
	input  logic [NB+1:0]                 cur_rem,
	input  logic [NB-1:0]                 cur_root,
	input  logic [2:0][rmq_pkg::DATA_W:0] cur_mag,
	output rmq_pkg::rmq_ctrl_t            nxt_ctrl,
	output logic [SQ_W-1:0]               nxt_rad,
	output logic [NB+1:0]                 nxt_rem,
	output logic [NB-1:0]                 nxt_root,
	output logic [2:0][rmq_pkg::DATA_W:0] nxt_mag
);
	import rmq_pkg::*;

	logic [NB+1:0] shifted, trial;
	logic          take;
	rmq_ctrl_t     ctrl_q;
	logic [SQ_W-1:0] rad_q;
	logic [NB+1:0] rem_q;
	logic [NB-1:0] root_q;
	logic [2:0][DATA_W:0] mag_q;

	assign shifted = {cur_rem[NB-1:0], cur_rad[SQ_W-1 -: 2]};
	assign trial   = {cur_root, 2'b01};
	assign take    = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= cur_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {cur_rad[SQ_W-3:0], 2'b00};
		rem_q  <= take ? shifted - trial : shifted;
		root_q <= {cur_root[NB-2:0], take};
		mag_q  <= cur_mag;
	end

	assign nxt_ctrl = ctrl_q;
	assign nxt_rad  = rad_q;
	assign nxt_rem  = rem_q;
	assign nxt_root = root_q;
	assign nxt_mag  = mag_q;

endmodule

/* hdl/rmq_div_cell.sv */
// ----------------------------------------------------------------------------
// rmq_div_cell
// one restoring division step for three lanes sharing the divisor 2*root
// ----------------------------------------------------------------------------
module rmq_div_cell #(
	parameter int NB = 17,
	parameter int NW = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmq_pkg::rmq_ctrl_t   cur_ctrl,
	input  logic [NB-1:0]        cur_root,
	input  logic [2:0][NB+1:0]   cur_rem,
	input  logic [2:0][NW-1:0]   cur_nq,
	output rmq_pkg::rmq_ctrl_t   nxt_ctrl,
	output logic [NB-1:0]        nxt_root,
	output logic [2:0][NB+1:0]   nxt_rem,
	output logic [2:0][NW-1:0]   nxt_nq
);
	import rmq_pkg::*;

	logic [NB+1:0]      divisor;
	logic [2:0][NB+1:0] t, rem_n;
	logic [2:0]         bit_n;
	rmq_ctrl_t          ctrl_q;
	logic [NB-1:0]      root_q;
	logic [2:0][NB+1:0] rem_q;
	logic [2:0][NW-1:0] nq_q;

	assign divisor = {1'b0, cur_root, 1'b0};

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			t[n]     = {cur_rem[n][NB:0], cur_nq[n][NW-1]};
			bit_n[n] = t[n] >= divisor;
			rem_n[n] = bit_n[n] ? t[n] - divisor : t[n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= cur_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		root_q <= cur_root;
		for (int n = 0; n < 3; n++) begin
			rem_q[n] <= rem_n[n];
			nq_q[n]  <= {cur_nq[n][NW-2:0], bit_n[n]};
		end
	end

	assign nxt_ctrl = ctrl_q;
	assign nxt_root = root_q;
	assign nxt_rem  = rem_q;
	assign nxt_nq   = nq_q;

endmodule

/* hdl/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// fixed-point rotation matrix to unit quaternion, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   a transaction is taken at a rising edge with start high and busy low;
//   busy is tied low, so a new matrix may be given in every cycle
//   matrix carries the nine signed entries, row-major
//   each result appears on quat for exactly one cycle with done high;
//   results leave in the order the matrices came in, one per matrix
// pipeline
//   1 front stage + NB root cells + NW divide cells + 1 output register;
//   NB = (AW + FRAC_BITS + 1) / 2, NW = DATA_W + 1 + FRAC_BITS,
//   with DATA_W and FRAC_BITS at their default Q2.14 format
// throughput
//   one transaction per cycle, set by the root and divide cell chains
// reset
//   arst_n clears every stage valid bit; nothing is in flight afterwards
//   the receiver cannot stall, so results are never held back
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rmq_pkg::rmq_matrix_t matrix,
	output logic                 done,
	output rmq_pkg::rmq_quat_t   quat
);
	import rmq_pkg::*;

	localparam int W    = DATA_W;
	// root argument width, large enough for 1.0 plus three entries
	localparam int AW   = ((FRAC_BITS > W + 1) ? FRAC_BITS : W + 1) + 2;
	localparam int NB   = (AW + FRAC_BITS + 1) / 2;
	localparam int SQ_W = 2 * NB;
	localparam int NW   = W + 1 + FRAC_BITS;

	localparam logic [63:0] POS_MAX = (64'd1 << (W - 1)) - 64'd1;
	localparam logic [63:0] NEG_MAG = 64'd1 << (W - 1);

	// root chain
	rmq_ctrl_t            sq_ctrl [NB+1];
	logic [SQ_W-1:0]      sq_rad  [NB+1];
	logic [NB+1:0]        sq_rem  [NB+1];
	logic [NB-1:0]        sq_root [NB+1];
	logic [2:0][W:0]      sq_mag  [NB+1];

	// divide chain
	rmq_ctrl_t            dv_ctrl [NW+1];
	logic [NB-1:0]        dv_root [NW+1];
	logic [2:0][NB+1:0]   dv_rem  [NW+1];
	logic [2:0][NW-1:0]   dv_nq   [NW+1];

	logic [NB-1:0]        half;
	logic [W-1:0]         half_sat;
	logic [2:0][W-1:0]    lane_sat;
	logic [W-1:0]         qx, qy, qz, qw;
	logic                 zero;
	rmq_ctrl_t            last;

	rmq_quat_t            quat_q;
	logic                 done_q;

	assign busy = 1'b0;

	rmq_front #(
		.FRAC_BITS (FRAC_BITS),
		.AW        (AW),
		.SQ_W      (SQ_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.matrix   (matrix),
		.nxt_ctrl (sq_ctrl[0]),
		.nxt_rad  (sq_rad[0]),
		.nxt_mag  (sq_mag[0])
	);

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar g = 0; g < NB; g++) begin : g_sqrt
		rmq_sqrt_cell #(
			.SQ_W (SQ_W),
			.NB   (NB)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cur_ctrl (sq_ctrl[g]),
			.cur_rad  (sq_rad[g]),
			.cur_rem  (sq_rem[g]),
			.cur_root (sq_root[g]),
			.cur_mag  (sq_mag[g]),
			.nxt_ctrl (sq_ctrl[g+1]),
			.nxt_rad  (sq_rad[g+1]),
			.nxt_rem  (sq_rem[g+1]),
			.nxt_root (sq_root[g+1]),
			.nxt_mag  (sq_mag[g+1])
		);
	end

	// numerators enter the divider as |d| * 2^FRAC_BITS
	assign dv_ctrl[0] = sq_ctrl[NB];
	assign dv_root[0] = sq_root[NB];
	always_comb begin
		for (int n = 0; n < 3; n++) begin
			dv_rem[0][n] = '0;
			dv_nq[0][n]  = {sq_mag[NB][n], {FRAC_BITS{1'b0}}};
		end
	end

	for (genvar g = 0; g < NW; g++) begin : g_div
		rmq_div_cell #(
			.NB (NB),
			.NW (NW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cur_ctrl (dv_ctrl[g]),
			.cur_root (dv_root[g]),
			.cur_rem  (dv_rem[g]),
			.cur_nq   (dv_nq[g]),
			.nxt_ctrl (dv_ctrl[g+1]),
			.nxt_root (dv_root[g+1]),
			.nxt_rem  (dv_rem[g+1]),
			.nxt_nq   (dv_nq[g+1])
		);
	end

	// saturation of the half root and the three signed quotients
	assign last = dv_ctrl[NW];
	assign zero = dv_root[NW] == '0;
	assign half = dv_root[NW] >> 1;
	assign half_sat = (64'(half) > POS_MAX) ? W'(POS_MAX) : W'(half);

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			if (last.neg[n]) begin
				lane_sat[n] = (64'(dv_nq[NW][n]) > NEG_MAG) ? W'(NEG_MAG)
				                                            : W'(-dv_nq[NW][n]);
			end else begin
				lane_sat[n] = (64'(dv_nq[NW][n]) > POS_MAX) ? W'(POS_MAX)
				                                            : dv_nq[NW][n][W-1:0];
			end
		end
	end

	// lane 0 goes to w unless w holds the root; lanes 1 and 2 follow cyclically
	always_comb begin
		unique case (last.sel)
			ROOT_X: begin
				qx = half_sat; qw = lane_sat[0]; qy = lane_sat[1]; qz = lane_sat[2];
			end
			ROOT_Y: begin
				qy = half_sat; qw = lane_sat[0]; qz = lane_sat[1]; qx = lane_sat[2];
			end
			ROOT_Z: begin
				qz = half_sat; qw = lane_sat[0]; qx = lane_sat[1]; qy = lane_sat[2];
			end
			default: begin
				qw = half_sat; qx = lane_sat[0]; qy = lane_sat[1]; qz = lane_sat[2];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	// a zero root clears every component and raises the flag
	always_ff @(posedge clk) begin
		quat_q.quat_x    <= zero ? '0 : qx;
		quat_q.quat_y    <= zero ? '0 : qy;
		quat_q.quat_z    <= zero ? '0 : qz;
		quat_q.quat_w    <= zero ? '0 : qw;
		quat_q.zero_root <= zero;
	end

	assign done = done_q;
	assign quat = quat_q;

endmodule

/* dv/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// watches matrix and quaternion transactions, predicts each quaternion with
// the shoemake method in fixed point and compares it field by field
// ----------------------------------------------------------------------------
module rmq_checker #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  rmq_pkg::rmq_matrix_t matrix,
	input  logic                 done,
	input  rmq_pkg::rmq_quat_t   quat,
	output int                   fail_count,
	output int                   pending,
	output int                   quat_seen,
	output int                   zero_root_seen
);
	import rmq_pkg::*;

	localparam int W = DATA_W;

	rmq_quat_t quat_expected_q[$];

	function automatic logic signed [63:0] root_of(logic signed [63:0] a);
		logic [63:0] v;
		logic [63:0] r;
		if (a <= 0) return 0;
		v = 64'(a) << FRAC_BITS;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
		end
		return $signed(r);
	endfunction

	function automatic logic signed [63:0] scale_by_root(logic signed [63:0] d,
			logic signed [63:0] s);
		return (d * (64'sd1 <<< FRAC_BITS)) / (2 * s);
	endfunction

	function automatic logic [W-1:0] clip(logic signed [63:0] v);
		logic signed [63:0] hi;
		hi = (64'sd1 <<< (W - 1)) - 1;
		if (v > hi) v = hi;
		if (v < -hi - 1) v = -hi - 1;
		return v[W-1:0];
	endfunction

	function automatic rmq_quat_t quat_from_matrix(rmq_matrix_t mx);
		logic signed [63:0] m [3][3];
		logic signed [63:0] q [4];
		logic signed [63:0] tr;
		logic signed [63:0] s;
		rmq_quat_t res;
		int i;
		int j;
		int k;
		m[0][0] = mx.m00; m[0][1] = mx.m01; m[0][2] = mx.m02;
		m[1][0] = mx.m10; m[1][1] = mx.m11; m[1][2] = mx.m12;
		m[2][0] = mx.m20; m[2][1] = mx.m21; m[2][2] = mx.m22;
		res.zero_root = 1'b0;
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			s = root_of((64'sd1 <<< FRAC_BITS) + tr);
			q[3] = s >>> 1;
			q[0] = scale_by_root(m[1][2] - m[2][1], s);
			q[1] = scale_by_root(m[2][0] - m[0][2], s);
			q[2] = scale_by_root(m[0][1] - m[1][0], s);
		end else begin
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			s = root_of((64'sd1 <<< FRAC_BITS) + (m[i][i] - (m[j][j] + m[k][k])));
			q[i] = s >>> 1;
			if (s != 0) begin
				q[3] = scale_by_root(m[j][k] - m[k][j], s);
				q[j] = scale_by_root(m[i][j] + m[j][i], s);
				q[k] = scale_by_root(m[i][k] + m[k][i], s);
			end else begin
				q[3] = 0; q[j] = 0; q[k] = 0;
				res.zero_root = 1'b1;
			end
		end
		res.quat_x = clip(q[0]);
		res.quat_y = clip(q[1]);
		res.quat_z = clip(q[2]);
		res.quat_w = clip(q[3]);
		return res;
	endfunction

	assign pending = quat_expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		rmq_quat_t want;
		if (!arst_n) begin
			fail_count     <= 0;
			quat_seen      <= 0;
			zero_root_seen <= 0;
		end else begin
			if (done) begin
				quat_seen <= quat_seen + 1;
				if (quat.zero_root) zero_root_seen <= zero_root_seen + 1;
				if (quat_expected_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected quaternion %h", quat);
					fail_count <= fail_count + 1;
				end else begin
					want = quat_expected_q.pop_front();
					if (want !== quat) begin
						if (fail_count < 10)
							$display("quat mismatch: exp x=%h y=%h z=%h w=%h zr=%b",
								want.quat_x, want.quat_y, want.quat_z, want.quat_w,
								want.zero_root, "  got x=%h y=%h z=%h w=%h zr=%b",
								quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w,
								quat.zero_root);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) quat_expected_q.push_back(quat_from_matrix(matrix));
		end
	end
endmodule

/* dv/tb_rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// drives directed and random matrices with random gaps; the checker
// beside the block predicts every quaternion and counts mismatches
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;
	import rmq_pkg::*;

	localparam int ONE     = 1 << FRAC_BITS_DEF;
	localparam int LATENCY = 60;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	rmq_matrix_t matrix;
	logic        done;
	rmq_quat_t   quat;
	int          fail_count;
	int          pending;
	int          quat_seen;
	int          zero_root_seen;

	rmq_matrix_t directed_q[$];

	rotation_matrix_to_quaternion i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.matrix (matrix),
		.done   (done),
		.quat   (quat)
	);

	rmq_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.matrix         (matrix),
		.done           (done),
		.quat           (quat),
		.fail_count     (fail_count),
		.pending        (pending),
		.quat_seen      (quat_seen),
		.zero_root_seen (zero_root_seen)
	);

	// free-running clock, period 12
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// hard stop in case the block hangs
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// small random value near zero so near-rotation and degenerate
	// matrices show up often
	function automatic logic [15:0] near(int span);
		return 16'($signed($urandom_range(2 * span)) - span);
	endfunction

	// one random matrix: mostly entries within +-1.0, some small ones with a
	// trace near -1.0, some with equal diagonal entries, the rest fully random
	function automatic rmq_matrix_t random_matrix();
		rmq_matrix_t mx;
		int pick;
		pick = $urandom_range(99);
		mx = rmq_matrix_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		if (pick < 55) begin
			mx.m00 = near(ONE); mx.m11 = near(ONE); mx.m22 = near(ONE);
			mx.m01 = near(ONE); mx.m02 = near(ONE); mx.m10 = near(ONE);
			mx.m12 = near(ONE); mx.m20 = near(ONE); mx.m21 = near(ONE);
		end else if (pick < 70) begin
			// small entries, trace hovering around -1.0
			mx.m00 = near(64) - 16'(ONE / 3); mx.m11 = near(64) - 16'(ONE / 3);
			mx.m22 = near(64) - 16'(ONE / 3);
			mx.m01 = near(200); mx.m10 = near(200); mx.m02 = near(200);
			mx.m20 = near(200); mx.m12 = near(200); mx.m21 = near(200);
		end else if (pick < 78) begin
			// equal diagonal entries to hit the tie rule
			mx.m00 = near(ONE);
			mx.m11 = ($urandom_range(1)) ? mx.m00 : near(ONE);
			mx.m22 = ($urandom_range(1)) ? mx.m00 : mx.m11;
		end
		return mx;
	endfunction

	function automatic rmq_matrix_t diag(int a, int b, int c);
		rmq_matrix_t mx;
		mx = '0;
		mx.m00 = 16'(a); mx.m11 = 16'(b); mx.m22 = 16'(c);
		return mx;
	endfunction

	// random gap, mostly none or short, now and then long
	task automatic idle_gap();
		int n;
		n = $urandom_range(99);
		if (n < 50) n = 0;
		else if (n < 92) n = $urandom_range(1, 3);
		else n = $urandom_range(8, 40);
		repeat (n) @(posedge clk);
	endtask

	task automatic send(rmq_matrix_t mx, bit gaps);
		start  <= 1'b1;
		matrix <= mx;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (gaps && $urandom_range(3) != 0) begin
			start <= 1'b0;
			idle_gap();
		end
	endtask

	initial begin
		rmq_matrix_t mx;
		int waited;
		arst_n = 1'b0;
		start  = 1'b0;
		matrix = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed transactions: identity, each branch, ties and field extremes
		directed_q.push_back(diag(ONE, ONE, ONE));
		directed_q.push_back(diag(ONE, -ONE, -ONE));
		directed_q.push_back(diag(-ONE, ONE, -ONE));
		directed_q.push_back(diag(-ONE, -ONE, ONE));
		directed_q.push_back(diag(0, 0, 0));
		directed_q.push_back(diag(-ONE / 3, -ONE / 3, -ONE / 3));
		directed_q.push_back(diag(-ONE / 2, -ONE / 2, 0));
		directed_q.push_back(diag(-32768, -32768, -32768));
		directed_q.push_back(diag(32767, 32767, 32767));
		directed_q.push_back(diag(32767, -32768, -32768));
		directed_q.push_back(diag(-32768, 32767, -32768));
		directed_q.push_back(diag(-32768, -32768, 32767));
		directed_q.push_back(diag(-ONE, -ONE, -ONE));
		directed_q.push_back(rmq_matrix_t'({9{16'h7fff}}));
		directed_q.push_back(rmq_matrix_t'({9{16'h8000}}));
		directed_q.push_back(rmq_matrix_t'({9{16'hffff}}));
		mx = diag(1, -32768, -32768);
		mx.m01 = 16'h7fff; mx.m10 = 16'h7fff; mx.m12 = 16'h8000; mx.m21 = 16'h7fff;
		directed_q.push_back(mx);
		mx = diag(0, 0, 1);
		mx.m01 = 16'h7fff; mx.m10 = 16'h8000; mx.m02 = 16'h8000; mx.m20 = 16'h7fff;
		directed_q.push_back(mx);
		mx = diag(ONE / 2, ONE / 2, -ONE);
		mx.m01 = 16'h5555; mx.m10 = 16'haaaa;
		directed_q.push_back(mx);
		foreach (directed_q[n]) send(directed_q[n], 1'b0);
		start <= 1'b0;
		idle_gap();

		// random part, with back-to-back stretches and gaps
		for (int n = 0; n < 800; n++) begin
			send(random_matrix(), (n / 100) % 2 == 1 || n > 600);
		end
		start <= 1'b0;

		// drain: wait for every expected quaternion, then keep watching for stray ones
		waited = 0;
		while (pending != 0 && waited < 20 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY) @(posedge clk);

		$display("sent %0d directed and 800 random matrices, checked %0d quaternions",
			directed_q.size(), quat_seen);
		$display("%0d of them with a zero root, %0d mismatches", zero_root_seen, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

/* rotation_matrix_to_quaternion.f */
hdl/rmq_pkg.sv
hdl/rmq_front.sv
hdl/rmq_sqrt_cell.sv
hdl/rmq_div_cell.sv
hdl/rotation_matrix_to_quaternion.sv
dv/rmq_checker.sv
dv/tb_rotation_matrix_to_quaternion.sv
